// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define IIRDF1_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define IIRDF1_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

// File: hw/rtl/iirdf1_pkg.sv
// Types, constants and command structures shared by the biquad filter modules.
`timescale 1ns / 1ps
package iirdf1_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int MUL_B_W    = 22;
    localparam int PROD_W     = 46;
    localparam int FF_W       = 42;
    localparam int SUM_W      = 64;
    localparam int NUM_W      = 44;
    localparam int QUOT_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 3;
    localparam int DIV_CNT_W  = 4;

    localparam int FF_ORDER   = 2;
    localparam int FB_ORDER   = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    localparam t_coef   ONE_Q20    = 24'sd1048576;
    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;
    localparam logic [QUOT_W-1:0] NEG_LIMIT = 16'h8000;

    localparam logic [STEP_W-1:0]    MAC_LAST_STEP = 3'd7;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 4'(QUOT_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_COEF_0 = 3'd0,
        REG_FF_COEF_1 = 3'd1,
        REG_FF_COEF_2 = 3'd2,
        REG_FB_COEF_0 = 3'd3,
        REG_FB_COEF_1 = 3'd4,
        REG_FB_COEF_2 = 3'd5,
        REG_GAIN      = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        TERM_B0X0     = 3'd0,
        TERM_B1X1     = 3'd1,
        TERM_B2X2     = 3'd2,
        TERM_A1Y1     = 3'd3,
        TERM_A2Y2     = 3'd4,
        TERM_G_FF_LO  = 3'd5,
        TERM_G_FF_HI  = 3'd6
    } t_term;

    typedef struct packed {
        t_coef ff_coef_0;
        t_coef ff_coef_1;
        t_coef ff_coef_2;
        t_coef fb_coef_0;
        t_coef fb_coef_1;
        t_coef fb_coef_2;
        t_coef gain;
    } t_coefs;

    typedef struct packed {
        logic  start;
        logic  mul_en;
        t_term mul_sel;
        logic  acc_en;
        t_term acc_sel;
        logic  check;
        logic  div_step;
        logic  finish;
    } t_dp_cmd;

endpackage

// File: hw/rtl/iirdf1_in_if.sv
// Input sample channel with valid/ready handshake.
`timescale 1ns / 1ps
interface iirdf1_in_if import iirdf1_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// File: hw/rtl/iirdf1_out_if.sv
// Output result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface iirdf1_out_if import iirdf1_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;
    logic    fault;

    modport source (output valid, output sample_out, output fault, input ready);
    modport sink (input valid, input sample_out, input fault, output ready);
endinterface

// File: hw/rtl/iirdf1_ctrl.sv
// Controller state machine that sequences the multiply, check, divide and finish steps.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iirdf1_ctrl import iirdf1_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MAC    = 5'b00010,
        S_CHECK  = 5'b00100,
        S_DIV    = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  w_accept;
    logic                  w_emit;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_emit   = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_div_cnt = r_div_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MAC;
                    n_step  = '0;
                end
            end
            S_MAC: begin
                if (r_step == MAC_LAST_STEP) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_CHECK: begin
                n_state   = S_DIV;
                n_div_cnt = '0;
            end
            S_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST_STEP) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = w_accept;
        o_cmd.mul_en   = (r_state == S_MAC) && (r_step != MAC_LAST_STEP);
        o_cmd.mul_sel  = t_term'(r_step);
        o_cmd.acc_en   = (r_state == S_MAC) && (r_step != '0);
        o_cmd.acc_sel  = t_term'(r_step - 1'b1);
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = w_emit;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `IIRDF1_ASSERT_NEXT(a_accept_starts_mac, w_accept, (r_state == S_MAC) && (r_step == '0))
    `IIRDF1_ASSERT_NEXT(a_result_waits, (r_state == S_FINISH) && r_out_valid && !i_out_ready, (r_state == S_FINISH) && r_out_valid)
    `IIRDF1_ASSERT_NOW(a_div_count_wrapped, r_state == S_FINISH, r_div_cnt == '0)

endmodule

// File: hw/rtl/iirdf1_dp.sv
// Datapath with the shared multiplier, accumulators, serial divider and sample histories.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iirdf1_dp import iirdf1_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_coefs  i_coefs,
    input  t_sample i_sample_in,
    output t_sample o_sample_out,
    output logic    o_fault
);

    t_sample                    r_x0, r_x1, r_x2, r_y1, r_y2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [FF_W-1:0]     r_ff, n_ff;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [COEF_W-1:0]          r_div;
    logic [COEF_W-1:0]          r_rem;
    logic [QUOT_W-1:0]          r_lo;
    logic                       r_ovf;
    logic                       r_q_neg;
    t_sample                    r_out_sample;
    logic                       r_fault;

    t_coef                      w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SUM_W-1:0]    w_abs_sum;
    logic [NUM_W-1:0]           w_num;
    logic [COEF_W-1:0]          w_abs_a0;
    logic                       w_ovf;
    logic [COEF_W:0]            w_rem_shift;
    logic [COEF_W:0]            w_rem_diff;
    logic                       w_ge;
    t_sample                    w_y;
    logic                       w_fault;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_sel)
            TERM_B0X0: begin
                w_mul_a = i_coefs.ff_coef_0;
                w_mul_b = {{(MUL_B_W-SAMPLE_W){r_x0[SAMPLE_W-1]}}, r_x0};
            end
            TERM_B1X1: begin
                w_mul_a = (FF_ORDER >= 1) ? i_coefs.ff_coef_1 : '0;
                w_mul_b = {{(MUL_B_W-SAMPLE_W){r_x1[SAMPLE_W-1]}}, r_x1};
            end
            TERM_B2X2: begin
                w_mul_a = (FF_ORDER >= 2) ? i_coefs.ff_coef_2 : '0;
                w_mul_b = {{(MUL_B_W-SAMPLE_W){r_x2[SAMPLE_W-1]}}, r_x2};
            end
            TERM_A1Y1: begin
                w_mul_a = (FB_ORDER >= 1) ? i_coefs.fb_coef_1 : '0;
                w_mul_b = {{(MUL_B_W-SAMPLE_W){r_y1[SAMPLE_W-1]}}, r_y1};
            end
            TERM_A2Y2: begin
                w_mul_a = (FB_ORDER >= 2) ? i_coefs.fb_coef_2 : '0;
                w_mul_b = {{(MUL_B_W-SAMPLE_W){r_y2[SAMPLE_W-1]}}, r_y2};
            end
            TERM_G_FF_LO: begin
                w_mul_a = i_coefs.gain;
                w_mul_b = {1'b0, r_ff[20:0]};
            end
            TERM_G_FF_HI: begin
                w_mul_a = i_coefs.gain;
                w_mul_b = {r_ff[FF_W-1], r_ff[FF_W-1:21]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        n_ff  = r_ff;
        n_sum = r_sum;
        if (i_cmd.start) begin
            n_ff  = '0;
            n_sum = '0;
        end else if (i_cmd.acc_en) begin
            case (i_cmd.acc_sel)
                TERM_B0X0, TERM_B1X1, TERM_B2X2: begin
                    n_ff = r_ff + r_prod[FF_W-1:0];
                end
                TERM_A1Y1, TERM_A2Y2: begin
                    n_sum = r_sum - {{4{r_prod[39]}}, r_prod[39:0], 20'b0};
                end
                TERM_G_FF_LO: begin
                    n_sum = r_sum + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                TERM_G_FF_HI: begin
                    n_sum = r_sum + {r_prod[42:0], 21'b0};
                end
                default: begin
                    n_sum = r_sum;
                end
            endcase
        end
    end

    assign w_abs_sum = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign w_num     = w_abs_sum[SUM_W-1:20];
    assign w_abs_a0  = i_coefs.fb_coef_0[COEF_W-1] ? COEF_W'(-i_coefs.fb_coef_0)
                                                   : i_coefs.fb_coef_0;
    assign w_ovf     = w_num >= {4'b0, w_abs_a0, 16'b0};

    assign w_rem_shift = {r_rem, r_lo[QUOT_W-1]};
    assign w_rem_diff  = w_rem_shift - {1'b0, r_div};
    assign w_ge        = w_rem_shift >= {1'b0, r_div};

    always_comb begin
        if (i_coefs.fb_coef_0 == '0) begin
            w_y     = '0;
            w_fault = 1'b1;
        end else if (r_ovf || (!r_q_neg && r_lo[QUOT_W-1]) || (r_q_neg && (r_lo > NEG_LIMIT))) begin
            w_y     = r_q_neg ? SAMPLE_MIN : SAMPLE_MAX;
            w_fault = 1'b1;
        end else begin
            w_y     = r_q_neg ? t_sample'(-r_lo) : t_sample'(r_lo);
            w_fault = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x0 <= i_sample_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        r_ff  <= n_ff;
        r_sum <= n_sum;
        if (i_cmd.check) begin
            r_div   <= w_abs_a0;
            r_rem   <= w_num[39:16];
            r_lo    <= w_num[15:0];
            r_ovf   <= w_ovf;
            r_q_neg <= r_sum[SUM_W-1] ^ i_coefs.fb_coef_0[COEF_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_diff[COEF_W-1:0] : w_rem_shift[COEF_W-1:0];
            r_lo  <= {r_lo[QUOT_W-2:0], w_ge};
        end
        if (i_cmd.finish) begin
            r_out_sample <= w_y;
            r_fault      <= w_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_cmd.finish) begin
            if (w_fault) begin
                r_x1 <= '0;
                r_x2 <= '0;
                r_y1 <= '0;
                r_y2 <= '0;
            end else begin
                r_x1 <= r_x0;
                r_x2 <= r_x1;
                r_y1 <= w_y;
                r_y2 <= r_y1;
            end
        end
    end

    assign o_sample_out = r_out_sample;
    assign o_fault      = r_fault;

    `IIRDF1_ASSERT_NEXT(a_start_loads_sample, i_cmd.start, r_x0 == $past(i_sample_in))
    `IIRDF1_ASSERT_NEXT(a_zero_divisor_out, i_cmd.finish && (i_coefs.fb_coef_0 == '0), (o_sample_out == '0) && o_fault)
    `IIRDF1_ASSERT_NEXT(a_history_update, i_cmd.finish, o_fault ? ((r_x1 == '0) && (r_x2 == '0) && (r_y1 == '0) && (r_y2 == '0)) : (r_y1 == o_sample_out))

endmodule

// File: hw/rtl/iir_direct_form_one_filter_unit.sv
// Top level of the direct form I biquad filter with its configuration registers.
//
//   Channel     Direction  Payload
//   i_sample    in         sample_in (Q1.15)
//   o_result    out        sample_out (Q1.15), fault
//   i_cfg_*     in         register index and 24-bit Q4.20 coefficient
//
// From acceptance until its result is loaded into the output register, an item passes
// through seven products on one shared 24 x 22 multiplier, one range check, and a
// 16-step restoring divider for the division by a0.
// The next sample is accepted as soon as the previous result is loaded, even if that
// result has not yet been taken; a finished result waits while the output register is full.
// Synchronous reset clears the histories and handshake state; a0 and the gain reset to one.
`timescale 1ns / 1ps
module iir_direct_form_one_filter_unit import iirdf1_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    iirdf1_in_if.sink            i_sample,
    iirdf1_out_if.source         o_result
);

    t_coefs  r_coefs, n_coefs;
    t_dp_cmd w_cmd;
    logic    w_in_ready;
    logic    w_out_valid;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FF_COEF_0: n_coefs.ff_coef_0 = i_cfg_data;
                REG_FF_COEF_1: n_coefs.ff_coef_1 = i_cfg_data;
                REG_FF_COEF_2: n_coefs.ff_coef_2 = i_cfg_data;
                REG_FB_COEF_0: n_coefs.fb_coef_0 = i_cfg_data;
                REG_FB_COEF_1: n_coefs.fb_coef_1 = i_cfg_data;
                REG_FB_COEF_2: n_coefs.fb_coef_2 = i_cfg_data;
                REG_GAIN:      n_coefs.gain      = i_cfg_data;
                default:       n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff_coef_0 <= '0;
            r_coefs.ff_coef_1 <= '0;
            r_coefs.ff_coef_2 <= '0;
            r_coefs.fb_coef_0 <= ONE_Q20;
            r_coefs.fb_coef_1 <= '0;
            r_coefs.fb_coef_2 <= '0;
            r_coefs.gain      <= ONE_Q20;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    iirdf1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    iirdf1_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_coefs      (r_coefs),
        .i_sample_in  (i_sample.sample_in),
        .o_sample_out (o_result.sample_out),
        .o_fault      (o_result.fault)
    );

    assign i_sample.ready = w_in_ready;
    assign o_result.valid = w_out_valid;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the direct form I biquad filter unit.
`timescale 1ns / 1ps
module tb_top;
    import iirdf1_pkg::*;

    localparam int REG_COUNT       = 7;
    localparam int LIMIT_CYCLES    = 500000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int HOLD_PHASE      = 3;
    localparam int PRINT_LIMIT     = 50;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam t_coef COEF_MAX = 24'sh7FFFFF;
    localparam t_coef COEF_MIN = 24'sh800000;

    typedef struct packed {
        t_sample sample_out;
        logic    fault;
    } t_expect;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        t_coef                 data;
        t_sample               x;
        bit                    typed;
        t_expect               want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    iirdf1_in_if  smp ();
    iirdf1_out_if res ();

    iir_direct_form_one_filter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (smp),
        .o_result   (res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_coef   coef_shadow [REG_COUNT];
    t_sample hist_x1, hist_x2, hist_y1, hist_y2;
    t_expect pending_outputs [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    bit      hold_request = 1'b0;

    function automatic t_expect filter_predict(input t_sample x0);
        longint  ff_sum, fb_sum, total, divisor, quotient;
        t_expect r;
        ff_sum = longint'(coef_shadow[REG_FF_COEF_0]) * x0
               + longint'(coef_shadow[REG_FF_COEF_1]) * hist_x1
               + longint'(coef_shadow[REG_FF_COEF_2]) * hist_x2;
        fb_sum = longint'(coef_shadow[REG_FB_COEF_1]) * hist_y1
               + longint'(coef_shadow[REG_FB_COEF_2]) * hist_y2;
        total = longint'(coef_shadow[REG_GAIN]) * ff_sum - (fb_sum <<< 20);
        r.fault = 1'b1;
        r.sample_out = '0;
        if (coef_shadow[REG_FB_COEF_0] != 0) begin
            divisor = longint'(coef_shadow[REG_FB_COEF_0]) <<< 20;
            quotient = total / divisor;
            if (quotient > SAMPLE_MAX) begin
                r.sample_out = SAMPLE_MAX;
            end else if (quotient < SAMPLE_MIN) begin
                r.sample_out = SAMPLE_MIN;
            end else begin
                r.sample_out = t_sample'(quotient);
                r.fault = 1'b0;
            end
        end
        if (r.fault) begin
            hist_x1 = '0;
            hist_x2 = '0;
            hist_y1 = '0;
            hist_y2 = '0;
        end else begin
            hist_x2 = hist_x1;
            hist_x1 = x0;
            hist_y2 = hist_y1;
            hist_y1 = r.sample_out;
        end
        return r;
    endfunction

    function automatic t_row write_row(input logic [CFG_IDX_W-1:0] idx, input t_coef data);
        t_row r;
        r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row sample_row(input t_sample x);
        t_row r;
        r = '{ROW_SAMPLE, '0, '0, x, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row checked_row(input t_sample x, input t_sample y, input logic flt);
        t_row r;
        r = '{ROW_SAMPLE, '0, '0, x, 1'b1, '{y, flt}};
        return r;
    endfunction

    function automatic t_coef coef_around(input int center, input int spread);
        return t_coef'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_coef data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < REG_COUNT) begin
            coef_shadow[idx] = data;
        end
        @(negedge i_clk);
    endtask

    task automatic send_sample(input t_sample x, input bit typed, input t_expect want);
        t_expect predicted;
        smp.valid <= 1'b1;
        smp.sample_in <= x;
        do @(posedge i_clk); while (!smp.ready);
        predicted = filter_predict(x);
        pending_outputs.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_expect want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("result with nothing expected", res.sample_out, 0);
            end else begin
                want = pending_outputs.pop_front();
                if (res.sample_out !== want.sample_out) begin
                    report_mismatch("sample_out", res.sample_out, want.sample_out);
                end
                if (res.fault !== want.fault) begin
                    report_mismatch("fault", res.fault, want.fault);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : result_sink
        int rx_cycle;
        rx_cycle = 0;
        res.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                rx_cycle++;
                case (rx_cycle[8:7])
                    2'd0: res.ready <= 1'b1;
                    2'd1: res.ready <= ($urandom_range(0, 2) != 0);
                    2'd2: res.ready <= ($urandom_range(0, 3) == 0);
                    default: res.ready <= rx_cycle[3];
                endcase
            end
        end
    end

    initial begin : stimulus
        t_row  plan [$];
        t_coef next_set [REG_COUNT];
        int    phase, n, r, mode;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        smp.valid <= 1'b0;
        smp.sample_in <= '0;

        for (r = 0; r < REG_COUNT; r++) begin
            coef_shadow[r] = '0;
        end
        coef_shadow[REG_FB_COEF_0] = ONE_Q20;
        coef_shadow[REG_GAIN] = ONE_Q20;
        hist_x1 = '0;
        hist_x2 = '0;
        hist_y1 = '0;
        hist_y2 = '0;

        plan = '{
            checked_row(SAMPLE_MAX, 16'sd0, 1'b0),
            checked_row(SAMPLE_MIN, 16'sd0, 1'b0),
            write_row(REG_FF_COEF_0, ONE_Q20),
            checked_row(SAMPLE_MAX, SAMPLE_MAX, 1'b0),
            checked_row(SAMPLE_MIN, SAMPLE_MIN, 1'b0),
            checked_row(16'sd0, 16'sd0, 1'b0),
            write_row(REG_GAIN, -ONE_Q20),
            checked_row(SAMPLE_MIN, SAMPLE_MAX, 1'b1),
            checked_row(SAMPLE_MAX, -16'sd32767, 1'b0),
            write_row(REG_GAIN, COEF_MAX),
            checked_row(SAMPLE_MAX, SAMPLE_MAX, 1'b1),
            checked_row(SAMPLE_MIN, SAMPLE_MIN, 1'b1),
            checked_row(16'sd1, 16'sd7, 1'b0),
            write_row(REG_FB_COEF_0, 24'sd0),
            checked_row(16'sd12345, 16'sd0, 1'b1),
            write_row(REG_FB_COEF_0, COEF_MIN),
            checked_row(SAMPLE_MAX, -16'sd32766, 1'b0),
            checked_row(SAMPLE_MIN, SAMPLE_MAX, 1'b0),
            write_row(REG_GAIN, ONE_Q20),
            write_row(REG_FB_COEF_0, ONE_Q20),
            write_row(REG_FF_COEF_1, COEF_MAX),
            write_row(REG_FF_COEF_2, COEF_MIN),
            write_row(REG_FB_COEF_1, COEF_MAX),
            write_row(REG_FB_COEF_2, COEF_MIN),
            write_row(REG_SPARE, 24'sh5A5A5A),
            sample_row(16'sd100),
            sample_row(-16'sd100),
            sample_row(SAMPLE_MAX),
            sample_row(SAMPLE_MIN),
            sample_row(16'sd0),
            sample_row(16'sd5),
            sample_row(16'sd1000),
            write_row(REG_FF_COEF_0, 24'sd524288),
            write_row(REG_FF_COEF_1, 24'sd524288),
            write_row(REG_FF_COEF_2, 24'sd262144),
            write_row(REG_FB_COEF_1, -24'sd524288),
            write_row(REG_FB_COEF_2, 24'sd262144),
            sample_row(16'sd20000),
            sample_row(16'sd20000),
            sample_row(-16'sd20000),
            sample_row(SAMPLE_MAX),
            sample_row(SAMPLE_MIN)
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_sample(plan[k].x, plan[k].typed, plan[k].want);
                pace_sender();
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            mode = $urandom_range(0, 4);
            for (r = 0; r < REG_COUNT; r++) begin
                if (phase == 0) begin
                    next_set[r] = COEF_MAX;
                end else if (phase == 1) begin
                    next_set[r] = COEF_MIN;
                end else if (mode == 3) begin
                    next_set[r] = t_coef'($urandom);
                end else begin
                    next_set[r] = coef_around(0, 1 << 19);
                end
            end
            // Mostly well-behaved filters; mode 4 uses a tiny divisor to force saturation.
            if (phase > 1 && mode != 3) begin
                next_set[REG_FB_COEF_0] = (mode == 4) ? coef_around(0, 1 << 12)
                                                      : coef_around(1 << 20, 1 << 19);
                next_set[REG_FB_COEF_1] = coef_around(0, 1 << 20);
                next_set[REG_FB_COEF_2] = coef_around(0, 1 << 18);
                next_set[REG_GAIN] = coef_around(1 << 20, 1 << 19);
            end
            for (r = 0; r < REG_COUNT; r++) begin
                write_reg(r[CFG_IDX_W-1:0], next_set[r]);
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_SPARE, t_coef'($urandom));
            end
            if (phase == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_sample(random_sample(), 1'b0, '0);
                pace_sender();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/iirdf1_pkg.sv
hw/rtl/iirdf1_in_if.sv
hw/rtl/iirdf1_out_if.sv
hw/rtl/iirdf1_ctrl.sv
hw/rtl/iirdf1_dp.sv
hw/rtl/iir_direct_form_one_filter_unit.sv
sim/tb_top.sv
